// ===== rtl/relay_cycle_tester_sequencer_defines.svh =====
// Assertion macros used by the relay cycle tester RTL (included by rcts_seq_core).
// Define ASSERT_OFF to compile the assertions out.
`ifndef RELAY_CYCLE_TESTER_SEQUENCER_DEFINES_SVH
`define RELAY_CYCLE_TESTER_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define RCTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RCTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RCTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RCTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/rcts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcts_pkg;

	// Width of the microsecond time base, which advances once per processed tick
	localparam int TIME_WIDTH = 32;
	localparam int DELAY_WIDTH = 32;
	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [DELAY_WIDTH-1:0] delay_t;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_CYCLE_TARGET     = 3'd0,
		REG_RESPONSE_TIMEOUT = 3'd1,
		REG_GAP_AFTER_ON     = 3'd2,
		REG_GAP_AFTER_OFF    = 3'd3,
		REG_CONTACT_SETTLE   = 3'd4,
		REG_POWER_SETTLE     = 3'd5
	} reg_idx_t;

	// Reset values of the registers
	localparam logic [15:0] CYCLE_TARGET_RST = 16'd1000;
	localparam logic [31:0] RESPONSE_TIMEOUT_RST = 32'd5000000;
	localparam logic [31:0] GAP_AFTER_ON_RST = 32'd100000;
	localparam logic [31:0] GAP_AFTER_OFF_RST = 32'd1000000;
	localparam logic [15:0] CONTACT_SETTLE_RST = 16'd3500;
	localparam logic [19:0] POWER_SETTLE_RST = 20'd20000;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_INIT     = 4'd1,
		PH_MEAS_ON  = 4'd2,
		PH_GAP_ON   = 4'd3,
		PH_MEAS_OFF = 4'd4,
		PH_UPDATE   = 4'd5,
		PH_GAP_OFF  = 4'd6,
		PH_STOP     = 4'd7,
		PH_RESET    = 4'd8,
		PH_ERROR    = 4'd9,
		PH_SETTLE   = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		RS_DONE     = 2'd0,
		RS_WORKING  = 2'd1,
		RS_STOP_REQ = 2'd2,
		RS_STOPPED  = 2'd3
	} run_status_t;

	typedef enum logic [1:0] {
		EK_NONE   = 2'd0,
		EK_CLOSED = 2'd1,
		EK_OPENED = 2'd2
	} edge_kind_t;

	typedef struct packed {
		logic [15:0] cycle_target;
		logic [31:0] response_timeout_us;
		logic [31:0] gap_after_on_us;
		logic [31:0] gap_after_off_us;
		logic [15:0] contact_settle_us;
		logic [19:0] power_settle_us;
	} cfg_t;

	typedef struct packed {
		logic start_click;
		logic stop_click;
		logic reset_hold;
		logic contact_active;
	} tick_t;

	typedef struct packed {
		logic        coil_drive;
		logic        load_power;
		phase_t      phase;
		run_status_t run_status;
		logic [15:0] cycles_done;
		logic [15:0] test_number;
		delay_t      on_time_us;
		delay_t      off_time_us;
		logic        record_valid;
		logic        test_passed;
		logic        test_failed;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/rcts_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tick channel: one item per microsecond
interface rcts_in_if;
	logic valid;
	logic ready;
	logic start_click;
	logic stop_click;
	logic reset_hold;
	logic contact_active;

	modport source (output valid, start_click, stop_click, reset_hold, contact_active,
		input ready);
	modport sink (input valid, start_click, stop_click, reset_hold, contact_active,
		output ready);
endinterface

// Result channel: one item per tick
interface rcts_out_if;
	logic        valid;
	logic        ready;
	logic        coil_drive;
	logic        load_power;
	logic [3:0]  phase;
	logic [1:0]  run_status;
	logic [15:0] cycles_done;
	logic [15:0] test_number;
	logic [31:0] on_time_us;
	logic [31:0] off_time_us;
	logic        record_valid;
	logic        test_passed;
	logic        test_failed;

	modport source (output valid, coil_drive, load_power, phase, run_status, cycles_done,
		test_number, on_time_us, off_time_us, record_valid, test_passed, test_failed,
		input ready);
	modport sink (input valid, coil_drive, load_power, phase, run_status, cycles_done,
		test_number, on_time_us, off_time_us, record_valid, test_passed, test_failed,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/relay_cycle_tester_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake       Payload
// tick      in   valid / ready   start_click, stop_click, reset_hold, contact_active
// result    out  valid / ready   coil/power levels, phase, status, counts, delays, pulses
// apb       in   psel / penable  six registers at byte address 4 * index, pready tied high
//
// One tick is registered at the input, evaluated combinationally, and its result is
// registered at the output; one tick per cycle is sustained while results are taken.
// A tick held in the input register waits only while the result register is full
// and not taken; the input side keeps taking ticks while the input register is free.
// Asynchronous reset clears the sequencer to idle and the registers to their defaults.

module relay_cycle_tester_sequencer
	import rcts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rcts_in_if.sink                    tick,
	rcts_out_if.source                 result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t  cfg;
	logic  valid_s1;
	tick_t tick_s1;
	logic  advance;

	rcts_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rcts_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.tick_s1  (tick_s1)
	);

	rcts_seq_core u_seq_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.tick_s1  (tick_s1),
		.advance  (advance),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== rtl/rcts_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcts_cfg_regs
	import rcts_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg    = cfg_q;

	// Register writes; unmapped indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycle_target        <= CYCLE_TARGET_RST;
			cfg_q.response_timeout_us <= RESPONSE_TIMEOUT_RST;
			cfg_q.gap_after_on_us     <= GAP_AFTER_ON_RST;
			cfg_q.gap_after_off_us    <= GAP_AFTER_OFF_RST;
			cfg_q.contact_settle_us   <= CONTACT_SETTLE_RST;
			cfg_q.power_settle_us     <= POWER_SETTLE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_CYCLE_TARGET:     cfg_q.cycle_target        <= pwdata[15:0];
				REG_RESPONSE_TIMEOUT: cfg_q.response_timeout_us <= pwdata;
				REG_GAP_AFTER_ON:     cfg_q.gap_after_on_us     <= pwdata;
				REG_GAP_AFTER_OFF:    cfg_q.gap_after_off_us    <= pwdata;
				REG_CONTACT_SETTLE:   cfg_q.contact_settle_us   <= pwdata[15:0];
				REG_POWER_SETTLE:     cfg_q.power_settle_us     <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_CYCLE_TARGET:     prdata = CFG_DATA_W'(cfg_q.cycle_target);
			REG_RESPONSE_TIMEOUT: prdata = cfg_q.response_timeout_us;
			REG_GAP_AFTER_ON:     prdata = cfg_q.gap_after_on_us;
			REG_GAP_AFTER_OFF:    prdata = cfg_q.gap_after_off_us;
			REG_CONTACT_SETTLE:   prdata = CFG_DATA_W'(cfg_q.contact_settle_us);
			REG_POWER_SETTLE:     prdata = CFG_DATA_W'(cfg_q.power_settle_us);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rcts_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcts_in_stage
	import rcts_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	rcts_in_if.sink     tick,
	input  wire logic   advance,
	output logic        valid_s1,
	output tick_t       tick_s1
);

	logic  vld_s1;
	tick_t data_s1;

	// Take a new tick whenever the register is empty or the held one moves on this cycle
	assign tick.ready = !vld_s1 || advance;
	assign valid_s1   = vld_s1;
	assign tick_s1    = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	// Payload, loaded on each transfer
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			data_s1.start_click    <= tick.start_click;
			data_s1.stop_click     <= tick.stop_click;
			data_s1.reset_hold     <= tick.reset_hold;
			data_s1.contact_active <= tick.contact_active;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rcts_seq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "relay_cycle_tester_sequencer_defines.svh"

module rcts_seq_core
	import rcts_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   valid_s1,
	input  wire tick_t  tick_s1,
	output logic        advance,
	rcts_out_if.source  result
);

	// Sequencer state
	phase_t      phase_q, phase_n;
	run_status_t status_q, status_n;
	logic [15:0] cycle_cnt_q, cycle_cnt_n;
	logic [15:0] test_cnt_q, test_cnt_n;
	logic        coil_q, coil_n;
	logic        power_q, power_n;
	time_t       now_q;
	time_t       phase_start_q, phase_start_n;
	time_t       edge_time_q, edge_time_n;
	edge_kind_t  edge_kind_q, edge_kind_n;
	logic        prev_contact_q;
	delay_t      on_delay_q, on_delay_n;
	delay_t      off_delay_q, off_delay_n;
	logic [19:0] settle_left_q, settle_left_n;

	// Output register
	logic        out_valid_q;
	result_t     res_q;

	logic        fire;
	logic        edge_seen;
	time_t       since_edge;
	time_t       since_start;
	logic        stable, is_on, is_off;
	logic        in_time;
	logic        rec, pass, fail;

	assign advance = !out_valid_q || result.ready;
	assign fire    = valid_s1 && advance;

	// Contact edge timestamping and stability
	always_comb begin
		edge_seen   = tick_s1.contact_active != prev_contact_q;
		edge_time_n = edge_seen ? now_q : edge_time_q;
		if (edge_seen) begin
			edge_kind_n = tick_s1.contact_active ? EK_CLOSED : EK_OPENED;
		end else begin
			edge_kind_n = edge_kind_q;
		end
		since_edge  = now_q - edge_time_n;
		since_start = now_q - phase_start_q;
		stable      = 64'(since_edge) > 64'(cfg.contact_settle_us);
		is_on       = stable && (edge_kind_n == EK_CLOSED);
		is_off      = stable && (edge_kind_n == EK_OPENED);
		in_time     = 64'(since_start) < 64'(cfg.response_timeout_us);
	end

	// Phase sequencer
	always_comb begin
		phase_n       = phase_q;
		status_n      = status_q;
		cycle_cnt_n   = cycle_cnt_q;
		test_cnt_n    = test_cnt_q;
		coil_n        = coil_q;
		power_n       = power_q;
		phase_start_n = phase_start_q;
		on_delay_n    = on_delay_q;
		off_delay_n   = off_delay_q;
		settle_left_n = settle_left_q;
		rec           = 1'b0;
		pass          = 1'b0;
		fail          = 1'b0;

		if (tick_s1.stop_click && phase_q != PH_SETTLE) begin
			status_n = RS_STOP_REQ;
		end

		case (phase_q)
			PH_INIT: begin
				status_n      = RS_WORKING;
				test_cnt_n    = test_cnt_q + 16'd1;
				cycle_cnt_n   = '0;
				power_n       = 1'b1;
				settle_left_n = cfg.power_settle_us;
				phase_n       = PH_SETTLE;
			end
			PH_MEAS_ON, PH_MEAS_OFF: begin
				// coil still at its old level: switch it and start timing
				if (coil_q == (phase_q == PH_MEAS_OFF)) begin
					coil_n        = !coil_q;
					phase_start_n = now_q;
				end else if (in_time) begin
					if (phase_q == PH_MEAS_ON && is_on) begin
						on_delay_n    = DELAY_WIDTH'(edge_time_n - phase_start_q);
						phase_start_n = now_q;
						phase_n       = PH_GAP_ON;
					end else if (phase_q == PH_MEAS_OFF && is_off) begin
						off_delay_n = DELAY_WIDTH'(edge_time_n - phase_start_q);
						phase_n     = PH_UPDATE;
					end
				end else begin
					coil_n  = 1'b0;
					power_n = 1'b0;
					fail    = 1'b1;
					phase_n = PH_ERROR;
				end
			end
			PH_GAP_ON: begin
				if (64'(since_start) > 64'(cfg.gap_after_on_us)) begin
					phase_n = PH_MEAS_OFF;
				end
			end
			PH_UPDATE: begin
				rec         = 1'b1;
				cycle_cnt_n = cycle_cnt_q + 16'd1;
				if (cycle_cnt_n == cfg.cycle_target) begin
					phase_n  = PH_IDLE;
					status_n = RS_DONE;
					pass     = 1'b1;
				end else if (status_n == RS_STOP_REQ) begin
					phase_n  = PH_STOP;
					status_n = RS_STOPPED;
					power_n  = 1'b0;
				end else begin
					phase_n = PH_GAP_OFF;
				end
				phase_start_n = now_q;
			end
			PH_GAP_OFF: begin
				if (64'(since_start) > 64'(cfg.gap_after_off_us)) begin
					phase_n = PH_MEAS_ON;
				end
			end
			PH_STOP: begin
				if (tick_s1.reset_hold) begin
					phase_n = PH_RESET;
				end else if (tick_s1.start_click) begin
					power_n       = 1'b1;
					settle_left_n = cfg.power_settle_us;
					phase_n       = PH_SETTLE;
				end
			end
			PH_RESET: begin
				power_n = 1'b0;
				if (tick_s1.start_click) begin
					test_cnt_n  = '0;
					cycle_cnt_n = '0;
					status_n    = RS_DONE;
					phase_n     = PH_IDLE;
				end else if (tick_s1.stop_click) begin
					status_n    = RS_DONE;
					cycle_cnt_n = '0;
					phase_n     = PH_IDLE;
				end
			end
			PH_ERROR: begin
				status_n    = RS_DONE;
				cycle_cnt_n = '0;
				power_n     = 1'b0;
				phase_n     = PH_IDLE;
			end
			PH_SETTLE: begin
				if (settle_left_q <= 20'd1) begin
					settle_left_n = '0;
					phase_n       = PH_MEAS_ON;
				end else begin
					settle_left_n = settle_left_q - 20'd1;
				end
			end
			default: begin
				// idle, and any code that means nothing
				status_n = RS_DONE;
				coil_n   = 1'b0;
				if (tick_s1.reset_hold) begin
					phase_n = PH_RESET;
				end else if (tick_s1.start_click) begin
					phase_n = PH_INIT;
				end else begin
					phase_n = PH_IDLE;
				end
			end
		endcase
	end

	// State update, one tick per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			status_q       <= RS_DONE;
			cycle_cnt_q    <= '0;
			test_cnt_q     <= '0;
			coil_q         <= 1'b0;
			power_q        <= 1'b0;
			now_q          <= '0;
			phase_start_q  <= '0;
			edge_time_q    <= '0;
			edge_kind_q    <= EK_NONE;
			prev_contact_q <= 1'b0;
			on_delay_q     <= '0;
			off_delay_q    <= '0;
			settle_left_q  <= '0;
		end else if (fire) begin
			phase_q        <= phase_n;
			status_q       <= status_n;
			cycle_cnt_q    <= cycle_cnt_n;
			test_cnt_q     <= test_cnt_n;
			coil_q         <= coil_n;
			power_q        <= power_n;
			now_q          <= now_q + TIME_WIDTH'(1);
			phase_start_q  <= phase_start_n;
			edge_time_q    <= edge_time_n;
			edge_kind_q    <= edge_kind_n;
			prev_contact_q <= tick_s1.contact_active;
			on_delay_q     <= on_delay_n;
			off_delay_q    <= off_delay_n;
			settle_left_q  <= settle_left_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.coil_drive   <= coil_n;
			res_q.load_power   <= power_n;
			res_q.phase        <= phase_n;
			res_q.run_status   <= status_n;
			res_q.cycles_done  <= cycle_cnt_n;
			res_q.test_number  <= test_cnt_n;
			res_q.on_time_us   <= on_delay_n;
			res_q.off_time_us  <= off_delay_n;
			res_q.record_valid <= rec;
			res_q.test_passed  <= pass;
			res_q.test_failed  <= fail;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.coil_drive   = res_q.coil_drive;
	assign result.load_power   = res_q.load_power;
	assign result.phase        = res_q.phase;
	assign result.run_status   = res_q.run_status;
	assign result.cycles_done  = res_q.cycles_done;
	assign result.test_number  = res_q.test_number;
	assign result.on_time_us   = res_q.on_time_us;
	assign result.off_time_us  = res_q.off_time_us;
	assign result.record_valid = res_q.record_valid;
	assign result.test_passed  = res_q.test_passed;
	assign result.test_failed  = res_q.test_failed;

	// Checks
	`RCTS_ASSERT_IMP(a_coil_needs_power, clk, arst_n, coil_q, power_q, "coil on without load power")
	`RCTS_ASSERT_IMP(a_pass_records, clk, arst_n, out_valid_q && res_q.test_passed, res_q.record_valid && res_q.phase == PH_IDLE, "pass without record")
	`RCTS_ASSERT_IMP(a_fail_shuts_down, clk, arst_n, out_valid_q && res_q.test_failed, res_q.phase == PH_ERROR && !res_q.coil_drive && !res_q.load_power, "fail without shutdown")
	`RCTS_ASSERT_NXT(a_error_to_idle, clk, arst_n, fire && phase_q == PH_ERROR, phase_q == PH_IDLE && cycle_cnt_q == 16'd0, "error phase did not return to idle")

endmodule

`default_nettype wire
